// File: hw/rtl/ppm_hp_pkg.sv
// Shared types and constants for the P6 image header parser.
// Used by the channel interfaces, all parser modules and the checker.
package ppm_hp_pkg;

   localparam int MAX_DIGITS  = 15;
   localparam int VALUE_BITS  = 16;
   localparam int DIGIT_BITS  = $clog2(MAX_DIGITS + 1);
   localparam int COUNT_BITS  = 4;
   localparam int MIN_BYTES   = 10;
   localparam int COUNT_MAX   = 15;

   localparam logic [VALUE_BITS-1:0] VALUE_MAX  = {VALUE_BITS{1'b1}};
   localparam logic [VALUE_BITS-1:0] MAXVAL_OK  = VALUE_BITS'(255);

   localparam logic [7:0] CHAR_P       = 8'h50;
   localparam logic [7:0] CHAR_SIX     = 8'h36;
   localparam logic [7:0] CHAR_HASH    = 8'h23;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_ACCEPT = 2'd0;
   localparam kind_type KIND_UNSUP  = 2'd1;
   localparam kind_type KIND_BROKEN = 2'd2;
   localparam kind_type KIND_PIXEL  = 2'd3;

   // One file byte as it moves from the input register to the parser.
   typedef struct packed {
      logic       valid;
      logic [7:0] data_byte;
      logic       is_last;
   } item_type;

   // One parse result as it moves from the parser to the result register.
   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic [15:0] width;
      logic [15:0] height;
      logic [7:0]  pixel_byte;
      logic        last_of_file;
   } result_type;

endpackage

// File: hw/rtl/ppm_hp_if.sv
// Valid/ready channel interfaces for the file byte stream and the results.
// Depends on ppm_hp_pkg for the result kind type.
interface ppm_hp_req_if
   import ppm_hp_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_last;

   modport source (output valid, output data_byte, output is_last, input ready);
   modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface ppm_hp_rsp_if
   import ppm_hp_pkg::*;
   ();
   logic        valid;
   logic        ready;
   kind_type    kind;
   logic [15:0] width;
   logic [15:0] height;
   logic [7:0]  pixel_byte;
   logic        last_of_file;

   modport source (output valid, output kind, output width, output height,
                   output pixel_byte, output last_of_file, input ready);
   modport sink   (input valid, input kind, input width, input height,
                   input pixel_byte, input last_of_file, output ready);
endinterface

// File: hw/rtl/ppm_hp_in_reg.sv
// Input register of the header parser: holds one file byte until the
// parser consumes it. Depends on ppm_hp_pkg for the item struct.
module ppm_hp_in_reg
   import ppm_hp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_is_last,
   input  logic       step,
   output item_type   item
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;

   // A new byte may enter when the register is empty or is drained this cycle.
   assign req_ready = !valid_ff || step;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_data_byte;
         last_ff <= req_is_last;
      end
   end

   assign item.valid     = valid_ff;
   assign item.data_byte = byte_ff;
   assign item.is_last   = last_ff;

endmodule

// File: hw/rtl/ppm_hp_parser.sv
// Header parse state and the one-byte step logic of the P6 parser.
// Depends on ppm_hp_pkg for constants, result kinds and structs.
module ppm_hp_parser
   import ppm_hp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  item_type   item,
   input  logic       step,
   output result_type result
);

   typedef enum logic [2:0] {
      PH_MAGIC1,
      PH_MAGIC2,
      PH_SKIP,
      PH_COMMENT,
      PH_DIGITS,
      PH_PIXELS,
      PH_DROP
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [1:0]             index_ff, index_in;
   logic [DIGIT_BITS-1:0]  digits_ff, digits_in;
   logic [VALUE_BITS-1:0]  acc_ff, acc_in;
   logic [VALUE_BITS-1:0]  wstore_ff, wstore_in;
   logic [VALUE_BITS-1:0]  hstore_ff, hstore_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;

   logic                   is_digit;
   logic [3:0]             digit_val;
   logic [VALUE_BITS+3:0]  product;
   logic                   has_res;
   kind_type               res_kind;
   logic [7:0]             b;

   assign b         = item.data_byte;
   assign is_digit  = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   assign digit_val = 4'(b - CHAR_ZERO);

   // acc * 10 + digit, as two shifted copies; saturated below.
   assign product = {acc_ff, 3'b000} + {2'b00, acc_ff, 1'b0}
                    + {(VALUE_BITS)'(0), digit_val};

   always_comb begin
      phase_in  = phase_ff;
      index_in  = index_ff;
      digits_in = digits_ff;
      acc_in    = acc_ff;
      wstore_in = wstore_ff;
      hstore_in = hstore_ff;
      count_in  = count_ff;
      has_res   = 1'b0;
      res_kind  = KIND_UNSUP;

      if (phase_ff == PH_PIXELS) begin
         has_res  = 1'b1;
         res_kind = KIND_PIXEL;
      end else if (phase_ff != PH_DROP) begin
         if (count_ff < COUNT_BITS'(COUNT_MAX)) begin
            count_in = count_ff + 1'b1;
         end
         case (phase_ff)
            PH_MAGIC1: begin
               if (b == CHAR_P) begin
                  phase_in = PH_MAGIC2;
               end else begin
                  has_res = 1'b1;
               end
            end
            PH_MAGIC2: begin
               if (b == CHAR_SIX) begin
                  phase_in = PH_SKIP;
               end else begin
                  has_res = 1'b1;
               end
            end
            PH_SKIP: begin
               if (is_digit) begin
                  acc_in    = VALUE_BITS'(digit_val);
                  digits_in = DIGIT_BITS'(1);
                  phase_in  = PH_DIGITS;
               end else if (b == CHAR_HASH) begin
                  phase_in = PH_COMMENT;
               end
            end
            PH_COMMENT: begin
               if (b == CHAR_NEWLINE) begin
                  phase_in = PH_SKIP;
               end
            end
            PH_DIGITS: begin
               if (is_digit && digits_ff < DIGIT_BITS'(MAX_DIGITS)) begin
                  if (product > {4'b0000, VALUE_MAX}) begin
                     acc_in = VALUE_MAX;
                  end else begin
                     acc_in = product[VALUE_BITS-1:0];
                  end
                  digits_in = digits_ff + 1'b1;
               end else if (index_ff == 2'd0) begin
                  wstore_in = acc_ff;
                  index_in  = 2'd1;
                  phase_in  = PH_SKIP;
               end else if (index_ff == 2'd1) begin
                  hstore_in = acc_ff;
                  index_in  = 2'd2;
                  phase_in  = PH_SKIP;
               end else begin
                  has_res = 1'b1;
                  if (wstore_ff != '0 && hstore_ff != '0 && acc_ff == MAXVAL_OK) begin
                     res_kind = KIND_ACCEPT;
                  end
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase

         // The file ended inside the header.
         if (!has_res && item.is_last) begin
            has_res = 1'b1;
            if (count_in < COUNT_BITS'(MIN_BYTES)) begin
               res_kind = KIND_UNSUP;
            end else begin
               res_kind = KIND_BROKEN;
            end
         end
         if (has_res) begin
            if (res_kind == KIND_ACCEPT) begin
               phase_in = PH_PIXELS;
            end else begin
               phase_in = PH_DROP;
            end
         end
      end

      // The final byte of any file returns the parser to its reset state.
      if (item.is_last) begin
         phase_in  = PH_MAGIC1;
         index_in  = 2'd0;
         digits_in = '0;
         acc_in    = '0;
         wstore_in = '0;
         hstore_in = '0;
         count_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_MAGIC1;
         index_ff  <= 2'd0;
         digits_ff <= '0;
         acc_ff    <= '0;
         wstore_ff <= '0;
         hstore_ff <= '0;
         count_ff  <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         index_ff  <= index_in;
         digits_ff <= digits_in;
         acc_ff    <= acc_in;
         wstore_ff <= wstore_in;
         hstore_ff <= hstore_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      result.valid        = item.valid && has_res;
      result.kind         = res_kind;
      result.width        = '0;
      result.height       = '0;
      result.pixel_byte   = '0;
      result.last_of_file = item.is_last;
      if (res_kind == KIND_ACCEPT) begin
         result.width  = wstore_ff[15:0];
         result.height = hstore_ff[15:0];
      end
      if (res_kind == KIND_PIXEL) begin
         result.pixel_byte = b;
      end
   end

endmodule

// File: hw/rtl/ppm_hp_out_reg.sv
// Result register of the header parser: holds one result until the
// receiver takes it. Depends on ppm_hp_pkg for the result struct.
module ppm_hp_out_reg
   import ppm_hp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  result_type  result,
   input  logic        load,
   output logic        free,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output kind_type    rsp_kind,
   output logic [15:0] rsp_width,
   output logic [15:0] rsp_height,
   output logic [7:0]  rsp_pixel_byte,
   output logic        rsp_last_of_file
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   // The register can take a new result when empty or emptied by this transfer.
   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = data_ff.kind;
   assign rsp_width        = data_ff.width;
   assign rsp_height       = data_ff.height;
   assign rsp_pixel_byte   = data_ff.pixel_byte;
   assign rsp_last_of_file = data_ff.last_of_file;

endmodule

// File: hw/rtl/ppm_header_parser_top.sv
// Top level of the P6 image header parser.
// Depends on ppm_hp_pkg, the channel interfaces and the parser modules.
//
// Usage: file bytes enter on the req channel, one per transfer, with is_last
// on the final byte of each file. The rsp channel gives at most one result
// per byte: header accepted (with width and height), unsupported file,
// broken file, or a pixel byte once the header has been accepted. After an
// error the rest of the file is dropped silently.
//
// Path: a byte that gives a result waits in the input register after its
// transfer; the parse step moves its result into the result register on rsp.
// Throughput: one byte per cycle unless a result is blocked; the header state
// takes a single short step per byte, the times-ten accumulate being the longest path.
//
// Reset: synchronous and active high; the parser waits for the magic of a
// new file and both registers are empty. The final byte of every file also
// returns the parser to that state. When the receiver stalls, a held result
// stays on rsp and the input register still takes bytes that give no
// result; req_ready drops only once a result is blocked behind the stall.
module ppm_header_parser_top
   import ppm_hp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   ppm_hp_req_if.sink        req_if,
   ppm_hp_rsp_if.source      rsp_if
);

   item_type   item;
   result_type result;
   logic       step;
   logic       out_free;

   // The parser consumes a byte unless its result cannot be stored yet.
   assign step = item.valid && (!result.valid || out_free);

   ppm_hp_in_reg u_in_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_ready     (req_if.ready),
      .req_data_byte (req_if.data_byte),
      .req_is_last   (req_if.is_last),
      .step          (step),
      .item          (item)
   );

   ppm_hp_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .item   (item),
      .step   (step),
      .result (result)
   );

   ppm_hp_out_reg u_out_reg (
      .clock            (clock),
      .reset            (reset),
      .result           (result),
      .load             (step && result.valid),
      .free             (out_free),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_kind         (rsp_if.kind),
      .rsp_width        (rsp_if.width),
      .rsp_height       (rsp_if.height),
      .rsp_pixel_byte   (rsp_if.pixel_byte),
      .rsp_last_of_file (rsp_if.last_of_file)
   );

endmodule

// File: hw/rtl/ppm_hp_checker.sv
// Port-level checks for the P6 header parser, bound to the top level.
// Depends on ppm_hp_pkg for the result kinds.
module ppm_hp_checker
   import ppm_hp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input kind_type    rsp_kind,
   input logic [15:0] rsp_width,
   input logic [15:0] rsp_height,
   input logic [7:0]  rsp_pixel_byte,
   input logic        rsp_last_of_file
);

   // A stalled result stays offered.
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its payload.
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_kind) && $stable(rsp_width)
         && $stable(rsp_height) && $stable(rsp_pixel_byte)
         && $stable(rsp_last_of_file))
      else $error("result payload changed while stalled");

   // An accepted header always carries non-zero dimensions.
   a_accept_dims: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ACCEPT |-> rsp_width != '0 && rsp_height != '0)
      else $error("header accepted with a zero dimension");

   // Only an accepted header reports dimensions.
   a_dims_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_ACCEPT |-> rsp_width == '0 && rsp_height == '0)
      else $error("dimensions reported without an accepted header");

   // Only a pixel result carries a data byte.
   a_pixel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_PIXEL |-> rsp_pixel_byte == '0)
      else $error("pixel byte reported on a header result");

endmodule

bind ppm_header_parser_top ppm_hp_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_kind         (rsp_if.kind),
   .rsp_width        (rsp_if.width),
   .rsp_height       (rsp_if.height),
   .rsp_pixel_byte   (rsp_if.pixel_byte),
   .rsp_last_of_file (rsp_if.last_of_file)
);

// File: tb/sv/ppm_header_checker.sv
`timescale 1ns / 1ps
// Result checker for the P6 header parser: watches both channels, predicts each
// result from the transferred file bytes and compares in order.
// Depends on ppm_hp_pkg and the channel interfaces in ppm_hp_if.sv.
module ppm_header_checker
   import ppm_hp_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   ppm_hp_req_if req_mon,
   ppm_hp_rsp_if rsp_mon,
   output int    error_count,
   output int    results_pending
);

   typedef enum logic [2:0] {
      PH_MAGIC_P,
      PH_MAGIC_SIX,
      PH_SKIP,
      PH_COMMENT,
      PH_DIGITS,
      PH_PIXELS,
      PH_DROP
   } parse_phase_e;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] width;
      logic [15:0] height;
      logic [7:0]  pixel_byte;
      logic        last_of_file;
   } file_result_t;

   parse_phase_e              phase;
   logic [1:0]                number_index;
   logic [DIGIT_BITS-1:0]     digit_count;
   logic [VALUE_BITS-1:0]     number_value;
   logic [VALUE_BITS-1:0]     width_seen;
   logic [VALUE_BITS-1:0]     height_seen;
   logic [COUNT_BITS-1:0]     header_bytes;
   file_result_t              awaited_results[$];

   function automatic void restart_file();
      phase        = PH_MAGIC_P;
      number_index = '0;
      digit_count  = '0;
      number_value = '0;
      width_seen   = '0;
      height_seen  = '0;
      header_bytes = '0;
   endfunction

   // Advances the parse state by one file byte; returns 1 when the byte
   // gives a result, which is then placed in r.
   function automatic bit parse_file_byte(input logic [7:0] b, input logic last,
                                          output file_result_t r);
      bit          is_digit;
      bit          has_result;
      kind_type    k;
      logic [31:0] grown;
      is_digit   = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      has_result = 1'b0;
      k          = KIND_UNSUP;
      r          = '0;
      r.last_of_file = last;
      if (phase == PH_DROP) begin
         if (last) restart_file();
         return 1'b0;
      end
      if (phase == PH_PIXELS) begin
         r.kind       = KIND_PIXEL;
         r.pixel_byte = b;
         if (last) restart_file();
         return 1'b1;
      end
      if (header_bytes < COUNT_MAX) header_bytes++;
      case (phase)
         PH_MAGIC_P: begin
            if (b == CHAR_P) phase = PH_MAGIC_SIX;
            else has_result = 1'b1;
         end
         PH_MAGIC_SIX: begin
            if (b == CHAR_SIX) phase = PH_SKIP;
            else has_result = 1'b1;
         end
         PH_SKIP: begin
            if (is_digit) begin
               number_value = VALUE_BITS'(b - CHAR_ZERO);
               digit_count  = 1;
               phase        = PH_DIGITS;
            end else if (b == CHAR_HASH) begin
               phase = PH_COMMENT;
            end
         end
         PH_COMMENT: begin
            if (b == CHAR_NEWLINE) phase = PH_SKIP;
         end
         default: begin
            if (is_digit && digit_count < MAX_DIGITS) begin
               grown = 32'(number_value) * 32'd10 + 32'(b) - 32'(CHAR_ZERO);
               number_value = (grown > 32'(VALUE_MAX)) ? VALUE_MAX
                                                       : grown[VALUE_BITS-1:0];
               digit_count++;
            end else if (number_index == 2'd0) begin
               width_seen   = number_value;
               number_index = 2'd1;
               phase        = PH_SKIP;
            end else if (number_index == 2'd1) begin
               height_seen  = number_value;
               number_index = 2'd2;
               phase        = PH_SKIP;
            end else begin
               has_result = 1'b1;
               if (width_seen != '0 && height_seen != '0 && number_value == MAXVAL_OK)
                  k = KIND_ACCEPT;
            end
         end
      endcase
      // A file that ends inside the header is judged by how long it was.
      if (!has_result && last) begin
         has_result = 1'b1;
         k = (header_bytes < MIN_BYTES) ? KIND_UNSUP : KIND_BROKEN;
      end
      if (!has_result) return 1'b0;
      r.kind = k;
      if (k == KIND_ACCEPT) begin
         r.width  = width_seen;
         r.height = height_seen;
         phase    = PH_PIXELS;
      end else begin
         phase = PH_DROP;
      end
      if (last) restart_file();
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      file_result_t predicted;
      file_result_t observed;
      if (reset) begin
         restart_file();
         awaited_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            observed.kind         = rsp_mon.kind;
            observed.width        = rsp_mon.width;
            observed.height       = rsp_mon.height;
            observed.pixel_byte   = rsp_mon.pixel_byte;
            observed.last_of_file = rsp_mon.last_of_file;
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected result: kind %0d w %0d h %0d px %0h last %0d",
                        $time, observed.kind, observed.width, observed.height,
                        observed.pixel_byte, observed.last_of_file);
               error_count++;
            end else begin
               predicted = awaited_results.pop_front();
               if (observed.kind !== predicted.kind
                   || observed.width !== predicted.width
                   || observed.height !== predicted.height
                   || observed.pixel_byte !== predicted.pixel_byte
                   || observed.last_of_file !== predicted.last_of_file) begin
                  $display("%0t: mismatch: expected kind %0d w %0d h %0d px %0h last %0d",
                           $time, predicted.kind, predicted.width, predicted.height,
                           predicted.pixel_byte, predicted.last_of_file);
                  $display("%0t:           actual   kind %0d w %0d h %0d px %0h last %0d",
                           $time, observed.kind, observed.width, observed.height,
                           observed.pixel_byte, observed.last_of_file);
                  error_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (parse_file_byte(req_mon.data_byte, req_mon.is_last, predicted))
               awaited_results.push_back(predicted);
         end
      end
      results_pending <= awaited_results.size();
   end

endmodule

// File: tb/sv/tb_ppm_header_parser_top.sv
`timescale 1ns / 1ps
// Testbench top for ppm_header_parser_top: clock, reset, file byte stimulus,
// receiver stalls and the verdict. Depends on ppm_hp_pkg, the channel
// interfaces, the parser RTL and ppm_header_checker.
module tb_ppm_header_parser_top;
   import ppm_hp_pkg::*;

   localparam int ITEM_TARGET = 800;
   localparam int HOLD_CYCLES = 300;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   int         error_count;
   int         results_pending;
   bit         sender_idles = 1'b1;
   bit         receiver_idles = 1'b1;
   int         hold_requests = 0;
   int         bytes_sent = 0;
   logic [7:0] file_bytes[$];

   ppm_hp_req_if req_if ();
   ppm_hp_rsp_if rsp_if ();

   ppm_header_parser_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   ppm_header_checker file_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_if),
      .rsp_mon         (rsp_if),
      .error_count     (error_count),
      .results_pending (results_pending)
   );

   always #5 clock = ~clock;

   initial begin
      #5ms;
      $display("DONE: errors detected");
      $finish;
   end

   // The receiver counts its long hold-off itself once the stimulus asks.
   initial begin : receiver
      int hold_left;
      int holds_seen;
      hold_left    = 0;
      holds_seen   = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (receiver_idles) begin
            rsp_if.ready <= ($urandom_range(0, 99) >= 33);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      while (sender_idles && $urandom_range(0, 99) < 33) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      req_if.is_last   <= last;
      do @(posedge clock); while (!req_if.ready);
      bytes_sent++;
   endtask

   task automatic send_file();
      foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
      file_bytes.delete();
   endtask

   // Holds the next file back until every predicted result has been seen.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
   endtask

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) file_bytes.push_back(s[i]);
   endfunction

   function automatic logic [7:0] pick_space();
      case ($urandom_range(0, 3))
         0: return 8'h20;
         1: return CHAR_NEWLINE;
         2: return 8'h09;
         default: return 8'h0D;
      endcase
   endfunction

   // Whitespace and comments between numbers; sometimes the comment opens
   // right after a number, so its '#' is taken as that number's delimiter.
   function automatic void add_gap();
      logic [7:0] c;
      int         body;
      if ($urandom_range(0, 9) >= 3)
         repeat ($urandom_range(1, 2)) file_bytes.push_back(pick_space());
      if ($urandom_range(0, 4) == 0 || file_bytes.size() == 2) begin
         file_bytes.push_back(CHAR_HASH);
         body = $urandom_range(0, 6);
         repeat (body) begin
            c = 8'($urandom_range(0, 255));
            if (c == CHAR_NEWLINE) c = 8'h41;
            file_bytes.push_back(c);
         end
         file_bytes.push_back(CHAR_NEWLINE);
      end
      if (file_bytes[file_bytes.size() - 1] == CHAR_SIX
          || $urandom_range(0, 3) == 0)
         file_bytes.push_back(pick_space());
   endfunction

   function automatic void add_number(input int unsigned n);
      if ($urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 3)) file_bytes.push_back(CHAR_ZERO);
      add_text($sformatf("%0d", n));
   endfunction

   function automatic void add_long_digits();
      repeat ($urandom_range(13, 20)) file_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
   endfunction

   function automatic int unsigned pick_dimension();
      case ($urandom_range(0, 9))
         0: return 1;
         1: return 65535;
         2: return $urandom_range(1000, 65535);
         default: return $urandom_range(1, 64);
      endcase
   endfunction

   function automatic void add_header(input int unsigned w, input int unsigned h,
                                      input int unsigned maxval);
      add_text("P6");
      add_gap();
      add_number(w);
      add_gap();
      add_number(h);
      add_gap();
      add_number(maxval);
      file_bytes.push_back(pick_space());
   endfunction

   function automatic void add_pixels(input int count);
      repeat (count) file_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   initial begin
      int file_index;
      int pick;
      int keep;
      req_if.valid     = 1'b0;
      req_if.data_byte = '0;
      req_if.is_last   = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: smallest good image with extreme pixel values, a one-byte
      // file with a bad first magic byte, a bad second magic byte followed by a
      // dropped byte, and a short file that ends inside the header.
      add_text("P6 1 1 255");
      file_bytes.push_back(CHAR_NEWLINE);
      file_bytes.push_back(8'hFF);
      file_bytes.push_back(8'h00);
      send_file();
      file_bytes.push_back(8'h00);
      send_file();
      add_text("P5");
      file_bytes.push_back(8'hFF);
      send_file();
      add_text("P6 9");
      send_file();
      drain_results();

      file_index = 0;
      while (bytes_sent < ITEM_TARGET) begin
         if (file_index == 10) begin
            sender_idles   = 1'b0;
            receiver_idles = 1'b0;
         end
         if (file_index == 25) begin
            sender_idles   = 1'b1;
            receiver_idles = 1'b1;
         end
         if (file_index == 40) drain_results();
         pick = $urandom_range(0, 99);
         if (file_index == 30) begin
            // The receiver stalls while a long image fills the block.
            hold_requests++;
            add_header(pick_dimension(), pick_dimension(), 255);
            add_pixels(60);
         end else if (pick < 50) begin
            add_header(pick_dimension(), pick_dimension(), 255);
            add_pixels($urandom_range(0, 12));
         end else if (pick < 62) begin
            case ($urandom_range(0, 3))
               0: add_header(0, pick_dimension(), 255);
               1: add_header(pick_dimension(), 0, 255);
               2: add_header(pick_dimension(), pick_dimension(), 254);
               default: add_header(pick_dimension(), pick_dimension(),
                                   $urandom_range(256, 99999));
            endcase
            add_pixels($urandom_range(0, 4));
         end else if (pick < 74) begin
            add_header(pick_dimension(), pick_dimension(), 255);
            add_pixels($urandom_range(0, 3));
            keep = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > keep) void'(file_bytes.pop_back());
         end else if (pick < 84) begin
            // Numbers at and past the digit limit, with saturation.
            add_text("P6 ");
            if ($urandom_range(0, 1)) add_long_digits(); else add_number(pick_dimension());
            add_gap();
            if ($urandom_range(0, 1)) add_long_digits(); else add_number(pick_dimension());
            add_gap();
            repeat ($urandom_range(10, 14)) file_bytes.push_back(CHAR_ZERO);
            add_text("255 ");
            add_pixels($urandom_range(0, 3));
         end else if (pick < 94) begin
            if ($urandom_range(0, 1)) add_text("P6");
            repeat ($urandom_range(1, 20)) file_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            if ($urandom_range(0, 1)) add_text("P");
            file_bytes.push_back(8'($urandom_range(0, 255)));
            add_pixels($urandom_range(0, 5));
         end
         send_file();
         file_index++;
      end

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
